// File: hw/rtl/hav_pkg.sv
`default_nettype none
package hav_pkg;

    localparam int MaxStages = 48;
    localparam int AngW      = 40;            // signed Q32 angle, ample headroom
    localparam int TrigW     = 36;            // signed Q31 sine/cosine plus growth
    localparam int VecW      = 36;            // vectoring x/y, Q31 roots
    localparam int RadW      = 23;
    localparam int OutW      = 35;

    localparam logic signed [AngW-1:0] PiQ32     = 40'sd13493037705;
    localparam logic signed [AngW-1:0] HalfPiQ32 = 40'sd6746518852;
    // round(pi * 2^60 / 1.8e9)
    localparam logic [31:0] RadScale = 32'd2012227627;
    localparam logic signed [TrigW-1:0] OneQ31 = 36'sd2147483648;

    typedef logic signed [AngW-1:0] t_ang;

    // atan(2^-i) in Q32, rounded
    function automatic t_ang atan_q32(input int i);
        unique case (i)
            0:  atan_q32 = 40'sd3373259426;
            1:  atan_q32 = 40'sd1991351318;
            2:  atan_q32 = 40'sd1052175346;
            3:  atan_q32 = 40'sd534100635;
            4:  atan_q32 = 40'sd268086748;
            5:  atan_q32 = 40'sd134174063;
            6:  atan_q32 = 40'sd67103403;
            7:  atan_q32 = 40'sd33553749;
            8:  atan_q32 = 40'sd16777131;
            9:  atan_q32 = 40'sd8388597;
            10: atan_q32 = 40'sd4194303;
            11: atan_q32 = 40'sd2097152;
            12: atan_q32 = 40'sd1048576;
            // half an lsb at 2^-33 rounds up, smaller angles vanish
            default: atan_q32 = (i <= 32) ? (t_ang'(1) <<< (32 - i))
                                          : ((i == 33) ? t_ang'(1) : t_ang'(0));
        endcase
    endfunction

    // 1/K in Q31 for the given stage count
    function automatic logic signed [TrigW-1:0] inv_gain(input int n);
        unique case (n)
            16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32,
            33, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45, 46, 47, 48:
                inv_gain = 36'sd1304065748;
            default: inv_gain = 36'sd1304065748;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/haversine_distance_top.sv
`default_nettype none
// channel | handshake         | payload
// input   | i_valid / o_ready | i_origin_lat, i_origin_lon, i_final_lat, i_final_lon
// output  | o_valid / i_ready | o_distance_mm
// config  | i_cfg_we          | i_cfg_data (earth_radius_m)
// one item per cycle when the output is not stalled
// the whole pipeline advances together, so a stall at the output holds every stage
// the two cordic pipelines (rotation, then vectoring) and the 32-stage square root
// set the latency
// synchronous active-low reset clears the valid bits and sets the radius register to 6371000
module haversine_distance_top #(
    parameter int CORDIC_STAGES = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire signed [30:0]   i_origin_lat,
    input  wire signed [31:0]   i_origin_lon,
    input  wire signed [30:0]   i_final_lat,
    input  wire signed [31:0]   i_final_lon,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [34:0]         o_distance_mm,
    input  wire                 i_cfg_we,
    input  wire [22:0]          i_cfg_data
);
    localparam int N  = CORDIC_STAGES;
    localparam int AW = hav_pkg::AngW;
    localparam int TW = hav_pkg::TrigW;
    localparam int VW = hav_pkg::VecW;
    localparam int L  = 2 * N + 42;

    logic en;
    logic [L-1:0] r_vld;
    logic [22:0] r_radius;

    assign o_valid = r_vld[L-1];
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= 23'd6371000;
        end else begin
            if (i_cfg_we) r_radius <= i_cfg_data;
            if (en) r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // stage 1: product to radians, input * scale
    logic signed [63:0] r_p [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= 64'(i_origin_lat) * $signed({1'b0, hav_pkg::RadScale});
            r_p[1] <= 64'(i_origin_lon) * $signed({1'b0, hav_pkg::RadScale});
            r_p[2] <= 64'(i_final_lat) * $signed({1'b0, hav_pkg::RadScale});
            r_p[3] <= 64'(i_final_lon) * $signed({1'b0, hav_pkg::RadScale});
        end
    end

    // stage 2: half differences and latitudes
    logic signed [AW-1:0] lat1, lon1, lat2, lon2;
    assign lat1 = AW'(r_p[0] >>> 28);
    assign lon1 = AW'(r_p[1] >>> 28);
    assign lat2 = AW'(r_p[2] >>> 28);
    assign lon2 = AW'(r_p[3] >>> 28);
    logic signed [AW-1:0] r_h [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h[0] <= (lat2 - lat1) >>> 1;
            r_h[1] <= (lon2 - lon1) >>> 1;
            r_h[2] <= lat1;
            r_h[3] <= lat2;
        end
    end

    // stage 3: fold into [-pi/2, pi/2]; up to three shifts by pi, enough for legal codes
    function automatic logic signed [AW:0] fold(input logic signed [AW-1:0] h);
        logic signed [AW-1:0] v;
        logic f;
        v = h;
        f = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (v > hav_pkg::HalfPiQ32) begin
                v = v - hav_pkg::PiQ32;
                f = !f;
            end else if (v < -hav_pkg::HalfPiQ32) begin
                v = v + hav_pkg::PiQ32;
                f = !f;
            end
        end
        fold = {f, v};
    endfunction

    logic signed [AW:0] fold_q [4];
    always_comb begin
        for (int k = 0; k < 4; k++) fold_q[k] = fold(r_h[k]);
    end

    logic signed [AW-1:0] r_z0 [4];
    logic [3:0] r_f0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_f0[k] <= fold_q[k][AW];
                r_z0[k] <= fold_q[k][AW-1:0];
            end
        end
    end

    // rotation cordic, four lanes
    logic signed [TW-1:0] rx [N+1][4];
    logic signed [TW-1:0] ry [N+1][4];
    logic signed [AW-1:0] rz [N+1][4];
    logic [3:0] rf [N+1];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rx[0][k] = hav_pkg::inv_gain(N);
            ry[0][k] = '0;
            rz[0][k] = r_z0[k];
        end
        rf[0] = r_f0;
    end
    for (genvar g = 0; g < N; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (en) begin
                rf[g+1] <= rf[g];
                for (int k = 0; k < 4; k++) begin
                    if (rz[g][k] >= 0) begin
                        rx[g+1][k] <= rx[g][k] - (ry[g][k] >>> g);
                        ry[g+1][k] <= ry[g][k] + (rx[g][k] >>> g);
                        rz[g+1][k] <= rz[g][k] - hav_pkg::atan_q32(g);
                    end else begin
                        rx[g+1][k] <= rx[g][k] + (ry[g][k] >>> g);
                        ry[g+1][k] <= ry[g][k] - (rx[g][k] >>> g);
                        rz[g+1][k] <= rz[g][k] + hav_pkg::atan_q32(g);
                    end
                end
            end
        end
    end

    function automatic logic signed [32:0] clampu(input logic signed [TW-1:0] v);
        if (v > hav_pkg::OneQ31) clampu = 33'sd2147483648;
        else if (v < -hav_pkg::OneQ31) clampu = -33'sd2147483648;
        else clampu = 33'(v);
    endfunction

    // stage A: clamp, sign of cosines, s1^2 and c1*c2
    logic signed [32:0] s1c, s2c, c1c, c2c;
    assign s1c = clampu(ry[N][0]);
    assign s2c = clampu(ry[N][1]);
    assign c1c = rf[N][2] ? -clampu(rx[N][2]) : clampu(rx[N][2]);
    assign c2c = rf[N][3] ? -clampu(rx[N][3]) : clampu(rx[N][3]);
    logic [63:0] r_s1sq_a;
    logic signed [65:0] r_cc;
    logic signed [32:0] r_s2_a;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1sq_a <= 64'(s1c * s1c);
            r_cc     <= 66'(c1c * c2c);
            r_s2_a   <= s2c;
        end
    end

    // stage B: t*s2
    logic signed [33:0] t_b;
    assign t_b = 34'(r_cc >>> 31);
    logic signed [66:0] r_ts;
    logic [63:0] r_s1sq_b;
    logic signed [32:0] r_s2_b;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ts     <= 67'(t_b * r_s2_a);
            r_s1sq_b <= r_s1sq_a;
            r_s2_b   <= r_s2_a;
        end
    end

    // stage C: u*s2
    logic signed [33:0] u_c;
    assign u_c = 34'(r_ts >>> 31);
    logic signed [66:0] r_w;
    logic [63:0] r_s1sq_c;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w      <= 67'(u_c * r_s2_b);
            r_s1sq_c <= r_s1sq_b;
        end
    end

    // stage D: haversine term, clamped to [0, 1] in Q62
    logic [62:0] a_d;
    logic [66:0] sum_d;
    always_comb begin
        sum_d = 67'(r_s1sq_c) + 67'(r_w);
        if (sum_d[66]) a_d = '0;
        else if (sum_d > 67'(64'd1 << 62)) a_d = 63'(64'd1 << 62);
        else a_d = sum_d[62:0];
    end
    logic [62:0] r_a, r_b;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= a_d;
            r_b <= 63'(64'd1 << 62) - a_d;
        end
    end

    // square roots: digit-recurrence, one result bit per stage, both lanes
    logic [63:0] sq_v [33][2];
    logic [31:0] sq_r [33][2];
    always_comb begin
        sq_v[0][0] = {1'b0, r_a};
        sq_v[0][1] = {1'b0, r_b};
        sq_r[0][0] = '0;
        sq_r[0][1] = '0;
    end
    for (genvar g = 0; g < 32; g++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 2; k++) begin
                    if (sq_v[g][k] >= ((64'(sq_r[g][k]) << (32 - g)) | (64'd1 << (62 - 2*g))))
                    begin
                        sq_v[g+1][k] <= sq_v[g][k] -
                            ((64'(sq_r[g][k]) << (32 - g)) | (64'd1 << (62 - 2*g)));
                        sq_r[g+1][k] <= sq_r[g][k] | (32'd1 << (31 - g));
                    end else begin
                        sq_v[g+1][k] <= sq_v[g][k];
                        sq_r[g+1][k] <= sq_r[g][k];
                    end
                end
            end
        end
    end

    // vectoring cordic on (sqrt(1-a), sqrt(a))
    logic signed [VW-1:0] vx [N+1];
    logic signed [VW-1:0] vy [N+1];
    logic signed [AW-1:0] vz [N+1];
    assign vx[0] = VW'(sq_r[32][1]);
    assign vy[0] = VW'(sq_r[32][0]);
    assign vz[0] = '0;
    for (genvar g = 0; g < N; g++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (vy[g] >= 0) begin
                    vx[g+1] <= vx[g] + (vy[g] >>> g);
                    vy[g+1] <= vy[g] - (vx[g] >>> g);
                    vz[g+1] <= vz[g] + hav_pkg::atan_q32(g);
                end else begin
                    vx[g+1] <= vx[g] - (vy[g] >>> g);
                    vy[g+1] <= vy[g] + (vx[g] >>> g);
                    vz[g+1] <= vz[g] - hav_pkg::atan_q32(g);
                end
            end
        end
    end

    // final stages: clamp angle, scale by radius in mm, round
    logic [33:0] z_e;
    always_comb begin
        if (vz[N] < 0) z_e = '0;
        else if (vz[N] > hav_pkg::HalfPiQ32) z_e = 34'(hav_pkg::HalfPiQ32);
        else z_e = 34'(vz[N]);
    end
    logic [33:0] r_c;
    logic [32:0] r_rmm;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c   <= {z_e[32:0], 1'b0};
            r_rmm <= 33'(r_radius) * 33'd1000;
        end
    end
    logic [66:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (en) r_prod <= 67'(r_rmm) * 67'(r_c) + 67'(64'd1 << 31);
    end
    // the largest radius times pi stays below 2^35 mm, so the top bits are the result
    logic [34:0] d_f;
    assign d_f = r_prod[66:32];
    always_ff @(posedge i_clk) begin
        if (en) o_distance_mm <= d_f;
    end

endmodule
`default_nettype wire

// File: hw/rtl/haversine_distance_checker.sv
`default_nettype none
module haversine_distance_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire o_ready,
    input wire o_valid,
    input wire i_ready,
    input wire [34:0] o_distance_mm
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance_mm))
        else $error("result changed under stall");
    // ready follows output side
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_rdy2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("ready while output stalled");
    // reset leaves no result
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind haversine_distance_top haversine_distance_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_distance_mm(o_distance_mm)
);
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
module testbench;

    localparam int NumStages = 32;
    localparam int Latency = 2 * NumStages + 42;
    localparam longint CycleLimit = 2000000;
    localparam longint unsigned OneQ60 = 64'd1 << 60;

    typedef struct packed {
        logic signed [30:0] origin_lat;
        logic signed [31:0] origin_lon;
        logic signed [30:0] final_lat;
        logic signed [31:0] final_lon;
    } t_points;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [30:0] i_origin_lat = '0;
    logic signed [31:0] i_origin_lon = '0;
    logic signed [30:0] i_final_lat = '0;
    logic signed [31:0] i_final_lon = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [34:0] o_distance_mm;
    logic i_cfg_we = 1'b0;
    logic [22:0] i_cfg_data = '0;

    haversine_distance_top #(.CORDIC_STAGES(NumStages)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_origin_lat(i_origin_lat), .i_origin_lon(i_origin_lon),
        .i_final_lat(i_final_lat), .i_final_lon(i_final_lon),
        .o_valid(o_valid), .i_ready(i_ready), .o_distance_mm(o_distance_mm),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_points point_pairs[$];
    logic [34:0] expected_mm[$];
    longint radius_m = 6371000;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic send_hold = 1'b0;
    logic recv_hold_req = 1'b0;
    logic recv_hold_done = 1'b0;
    int recv_hold_cnt = 0;
    int mismatches = 0;
    longint cycles = 0;

    longint atan_q32[48];
    longint pi_q32, half_pi_q32, inv_gain_q31, rad_scale;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint arctan_recip_q60(input longint n);
        longint p, sum, k, t;
        bit neg;
        p = longint'(OneQ60 / longint'(n));
        sum = 0;
        k = 0;
        neg = 0;
        while (p > 0) begin
            t = p / (2 * k + 1);
            sum = neg ? sum - t : sum + t;
            neg = !neg;
            k++;
            p = p / (n * n);
        end
        return sum;
    endfunction

    function automatic longint arctan_pow2_q60(input int i);
        longint unsigned p;
        longint sum, k, t;
        bit neg;
        p = OneQ60 >> i;
        sum = 0;
        k = 0;
        neg = 0;
        while (p != 0) begin
            t = longint'(p / longint'(2 * k + 1));
            sum = neg ? sum - t : sum + t;
            neg = !neg;
            k++;
            p = (2 * i < 64) ? (p >> (2 * i)) : 0;
        end
        return sum;
    endfunction

    task automatic build_constants();
        longint pi_q60;
        longint unsigned g, k;
        pi_q60 = 16 * arctan_recip_q60(5) - 4 * arctan_recip_q60(239);
        pi_q32 = (pi_q60 + (64'sd1 << 27)) >>> 28;
        half_pi_q32 = pi_q32 / 2;
        rad_scale = (pi_q60 + 900000000) / 1800000000;
        atan_q32[0] = (pi_q60 / 4 + (64'sd1 << 27)) >>> 28;
        for (int i = 1; i < 48; i++)
            atan_q32[i] = (arctan_pow2_q60(i) + (64'sd1 << 27)) >>> 28;
        g = OneQ60;
        for (int i = 0; i < NumStages; i++)
            g = g + ((2 * i < 64) ? (g >> (2 * i)) : 0);
        k = floor_sqrt(g);
        inv_gain_q31 = longint'(((64'd1 << 61) + k / 2) / k);
    endtask

    function automatic longint unit_clamp(input longint v);
        longint one;
        one = 64'sd1 << 31;
        return v > one ? one : (v < -one ? -one : v);
    endfunction

    // rotation mode: returns sine, cosine via output arguments
    function automatic void rotate(input longint th, output longint s, output longint c);
        longint x, y, z, dx, dy;
        x = inv_gain_q31;
        y = 0;
        z = th;
        for (int i = 0; i < NumStages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_q32[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_q32[i];
            end
        end
        s = unit_clamp(y);
        c = unit_clamp(x);
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < NumStages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + atan_q32[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_q32[i];
            end
        end
        if (z < 0) z = 0;
        if (z > half_pi_q32) z = half_pi_q32;
        return z;
    endfunction

    // move into [-pi/2, pi/2], toggling the cosine sign each step
    function automatic longint wrap_half_pi(input longint h, inout bit flip);
        while (h > half_pi_q32) begin
            h = h - pi_q32;
            flip = !flip;
        end
        while (h < -half_pi_q32) begin
            h = h + pi_q32;
            flip = !flip;
        end
        return h;
    endfunction

    function automatic logic [34:0] distance_mm(input t_points p, input longint radius);
        longint lat1, lon1, lat2, lon2, s1, s2, c1, c2, unused, t, u, w, z, c;
        longint unsigned s1sq, a, rmm, hi, lo, d, mag;
        bit flip, f1, f2;
        flip = 0; f1 = 0; f2 = 0;
        lat1 = (longint'(p.origin_lat) * rad_scale) >>> 28;
        lon1 = (longint'(p.origin_lon) * rad_scale) >>> 28;
        lat2 = (longint'(p.final_lat) * rad_scale) >>> 28;
        lon2 = (longint'(p.final_lon) * rad_scale) >>> 28;
        rotate(wrap_half_pi((lat2 - lat1) >>> 1, flip), s1, unused);
        rotate(wrap_half_pi((lon2 - lon1) >>> 1, flip), s2, unused);
        rotate(wrap_half_pi(lat1, f1), unused, c1);
        rotate(wrap_half_pi(lat2, f2), unused, c2);
        if (f1) c1 = -c1;
        if (f2) c2 = -c2;
        s1sq = longint'(s1 * s1);
        t = (c1 * c2) >>> 31;
        u = (t * s2) >>> 31;
        w = u * s2;
        if (w < 0) begin
            mag = longint'(-w);
            a = s1sq > mag ? s1sq - mag : 0;
        end else begin
            a = s1sq + longint'(w);
            if (a > (64'd1 << 62)) a = 64'd1 << 62;
        end
        z = vector_angle(longint'(floor_sqrt(a)), longint'(floor_sqrt((64'd1 << 62) - a)));
        c = 2 * z;
        rmm = longint'(radius) * 1000;
        hi = rmm * (longint'(c) >> 16);
        lo = rmm * (longint'(c) & 64'hFFFF) + (64'd1 << 31);
        d = (hi + (lo >> 16)) >> 16;
        if (d > 64'h7_FFFF_FFFF) d = 64'h7_FFFF_FFFF;
        return d[34:0];
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_mm.push_back(distance_mm({i_origin_lat, i_origin_lon,
                                                   i_final_lat, i_final_lon}, radius_m));
            if (!i_valid || o_ready) begin
                if (point_pairs.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_origin_lat <= point_pairs[0].origin_lat;
                    i_origin_lon <= point_pairs[0].origin_lon;
                    i_final_lat <= point_pairs[0].final_lat;
                    i_final_lon <= point_pairs[0].final_lon;
                    void'(point_pairs.pop_front());
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_mm.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected item: distance %0d", o_distance_mm);
                end else begin
                    if (o_distance_mm !== expected_mm[0]) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("distance mismatch: expected %0d actual %0d",
                                     expected_mm[0], o_distance_mm);
                    end
                    void'(expected_mm.pop_front());
                end
            end
            if (recv_hold_req && !recv_hold_done) begin
                recv_hold_done <= 1'b1;
                recv_hold_cnt <= 400;
                i_ready <= 1'b0;
            end else if (recv_hold_cnt > 0) begin
                recv_hold_cnt <= recv_hold_cnt - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic wait_drained();
        while (point_pairs.size() > 0 || i_valid || expected_mm.size() > 0)
            @(posedge i_clk);
        repeat (Latency + 5) @(posedge i_clk);
    endtask

    task automatic set_radius(input logic [22:0] r);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        radius_m = r;
        @(posedge i_clk);
    endtask

    task automatic add_pair(input longint la1, input longint lo1, input longint la2,
                            input longint lo2);
        t_points p;
        p.origin_lat = la1[30:0];
        p.origin_lon = lo1[31:0];
        p.final_lat = la2[30:0];
        p.final_lon = lo2[31:0];
        point_pairs.push_back(p);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                // full field range, beyond the poles and the date line
                add_pair(longint'($signed($urandom())) >>> 1, $signed($urandom()),
                         longint'($signed($urandom())) >>> 1, $signed($urandom()));
            end else if ($urandom_range(4) == 0) begin
                // nearby points
                longint la, lo;
                la = longint'($urandom_range(1800000000)) - 900000000;
                lo = longint'($urandom_range(3600000000)) - 1800000000;
                add_pair(la, lo, la + $urandom_range(20000) - 10000,
                         lo + $urandom_range(20000) - 10000);
            end else begin
                add_pair(longint'($urandom_range(1800000000)) - 900000000,
                         longint'($urandom_range(3600000000)) - 1800000000,
                         longint'($urandom_range(1800000000)) - 900000000,
                         longint'($urandom_range(3600000000)) - 1800000000);
            end
        end
    endtask

    initial begin
        build_constants();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 22;
        recv_idle_pct = 88;

        // directed: extremes, same point, antipodes, beyond range
        add_pair(0, 0, 0, 0);
        add_pair(900000000, 0, -900000000, 0);
        add_pair(0, -1800000000, 0, 1800000000);
        add_pair(0, 0, 0, 1800000000);
        add_pair(450000000, 1000000000, -450000000, -800000000);
        add_pair(900000000, 1800000000, 900000000, -1800000000);
        add_pair(-900000000, 123456789, -900000000, -987654321);
        add_pair(123456789, 987654321, 123456789, 987654321);
        add_pair(123456789, 987654321, 123456790, 987654322);
        add_pair(-1073741824, -2147483648, 1073741823, 2147483647);
        add_pair(1073741823, 2147483647, -1073741824, -2147483648);
        add_pair(1073741823, 0, 0, 0);
        add_pair(-1073741824, 0, 1073741823, 2147483647);
        add_pair(0, 2147483647, 0, -2147483648);
        add_pair(515000000, -1270000, 407000000, -740000000);
        add_pair(-338000000, 1512000000, 516000000, -1300000);
        add_pair(899999999, 0, 900000000, 1);
        add_pair(1, 1, -1, -1);
        wait_drained();

        set_radius(23'd6350000);
        add_random(300);

        set_radius(23'd6400000);
        send_idle_pct = 88;
        recv_idle_pct = 22;
        add_random(150);
        while (point_pairs.size() > 100) @(posedge i_clk);
        send_idle_pct = 0;
        recv_hold_req <= 1'b1;
        add_random(100);
        // pause until everything is back
        wait_drained();
        send_hold <= 1'b1;
        repeat (20) @(posedge i_clk);
        send_hold <= 1'b0;
        send_idle_pct = 88;

        set_radius(23'd0);
        add_pair(900000000, 0, -900000000, 0);
        add_random(10);

        set_radius(23'h7FFFFF);
        add_pair(900000000, 0, -900000000, 0);
        add_pair(0, 0, 0, 1800000000);
        add_random(20);

        set_radius(23'd6371000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(300);

        wait_drained();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
